[rtl/scba_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// scba_pkg
// Shared types, codes and defaults for the size-class bitmap slot allocator.
// ---------------------------------------------------------------------------
package scba_pkg;

  localparam int NUM_CLASSES_DEF     = 16;
  localparam int SLOTS_PER_CLASS_DEF = 64;

  // Width of a raw class number: ceil_log2 of a 33-bit value is 0..33
  localparam int RAW_CLS_W = 6;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [1:0] STS_OK       = 2'd0;
  localparam logic [1:0] STS_NO_CLASS = 2'd1;
  localparam logic [1:0] STS_FULL     = 2'd2;
  localparam logic [1:0] STS_BAD_SLOT = 2'd3;

  typedef struct packed {
    logic                 no_class;
    logic [RAW_CLS_W-1:0] cls;
  } cls_info_t;

endpackage

`default_nettype wire

[rtl/scba_class_calc.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// scba_class_calc
// Round an allocate request to its alignment and pick the power-of-two size class.
// ---------------------------------------------------------------------------
module scba_class_calc #(
  parameter int NUM_CLASSES = scba_pkg::NUM_CLASSES_DEF
) (
  input  wire logic              action,
  input  wire logic [31:0]       request_bytes,
  input  wire logic [4:0]        align_log2,
  output scba_pkg::cls_info_t    info
);
  import scba_pkg::*;

  logic [32:0] size;
  logic [32:0] amask;
  logic [32:0] rounded;
  logic [32:0] vm1;
  logic [RAW_CLS_W-1:0] c;

  always_comb begin
    size    = (request_bytes == 32'd0) ? 33'd1 : {1'b0, request_bytes};
    amask   = (33'd1 << align_log2) - 33'd1;
    rounded = (action == ACT_ALLOC) ? ((size + amask) & ~amask) : size;
    vm1     = rounded - 33'd1;
    // ceil_log2: one above the top set bit of value minus one
    c = '0;
    for (int i = 0; i < 33; i++) begin
      if (vm1[i]) begin
        c = RAW_CLS_W'(i + 1);
      end
    end
    info.cls      = c;
    info.no_class = ({1'b0, c} >= (RAW_CLS_W + 1)'(NUM_CLASSES));
  end

endmodule

`default_nettype wire

[rtl/scba_map_ram.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// scba_map_ram
// Free-bitmap memory, one word per class, registered read. Entries not yet
// written since reset read as all slots free.
// ---------------------------------------------------------------------------
module scba_map_ram #(
  parameter int DEPTH = scba_pkg::NUM_CLASSES_DEF,
  parameter int WIDTH = scba_pkg::SLOTS_PER_CLASS_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic      [WIDTH-1:0] rd_data
);
  import scba_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] data_r;
  logic             fresh_r;
  logic [DEPTH-1:0] written_r;
  logic [DEPTH-1:0] written_nxt;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      data_r  <= mem[rd_addr];
      fresh_r <= !written_r[rd_addr];
    end
  end

  always_comb begin
    written_nxt = written_r;
    if (wr_en) begin
      written_nxt[wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= '0;
    end else begin
      written_r <= written_nxt;
    end
  end

  assign rd_data = fresh_r ? {WIDTH{1'b1}} : data_r;

endmodule

`default_nettype wire

[rtl/size_class_bitmap_slot_allocator.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// size_class_bitmap_slot_allocator
// Power-of-two size-class slot allocator over per-class free bitmaps.
// ---------------------------------------------------------------------------
// Usage:
//   Command channel: drive in_* and raise start; a transaction is taken at a
//   rising edge with start high and busy low. in_action selects allocate
//   (claim lowest free slot of the class) or free (release in_slot_to_free).
//   Result channel: out_valid strobes for exactly one cycle with out_status,
//   out_size_class, out_slot_index and out_granted_bytes. The receiver cannot
//   stall; a result that is not sampled in that cycle is gone.
//   out_valid and the result are registered together at the close of busy.
//   Steps: the accepting edge issues the bitmap read for the class; the next
//   cycle finds the slot, writes the word back and registers the result. busy
//   is high for that one cycle, and no new transaction is taken while it is.
//   A new transaction may be accepted while the previous result is showing.
//   Reset (rst_n low, synchronous) drops any transaction in flight, clears
//   the strobe and marks every slot of every class free at once; the block
//   is idle after reset and takes a command as soon as rst_n is released.
// ---------------------------------------------------------------------------
module size_class_bitmap_slot_allocator #(
  parameter int NUM_CLASSES     = scba_pkg::NUM_CLASSES_DEF,
  parameter int SLOTS_PER_CLASS = scba_pkg::SLOTS_PER_CLASS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_action,
  input  wire logic [31:0] in_request_bytes,
  input  wire logic [4:0]  in_align_log2,
  input  wire logic [5:0]  in_slot_to_free,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic [3:0]       out_size_class,
  output logic [5:0]       out_slot_index,
  output logic [15:0]      out_granted_bytes
);
  import scba_pkg::*;

  localparam int AW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int SW = SLOTS_PER_CLASS;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RMW  = 1'b1;

  logic state_r, state_nxt;
  logic accept;

  cls_info_t in_info;

  // Held transaction for the read-modify-write cycle
  logic                 op_action_r;
  logic                 op_no_class_r;
  logic [RAW_CLS_W-1:0] op_cls_r;
  logic [5:0]           op_slot_r;

  logic [SW-1:0] word;
  logic [SW-1:0] wr_word;
  logic          wr_en;
  logic          any_free;
  logic [5:0]    first_free;
  logic          slot_bad;

  logic [1:0]  res_status;
  logic [3:0]  res_cls;
  logic [5:0]  res_idx;
  logic [15:0] res_granted;

  logic        out_valid_r;
  logic [1:0]  out_status_r;
  logic [3:0]  out_size_class_r;
  logic [5:0]  out_slot_index_r;
  logic [15:0] out_granted_bytes_r;

  assign busy   = (state_r == ST_RMW);
  assign accept = start && !busy;

  scba_class_calc #(
    .NUM_CLASSES (NUM_CLASSES)
  ) u_calc (
    .action        (in_action),
    .request_bytes (in_request_bytes),
    .align_log2    (in_align_log2),
    .info          (in_info)
  );

  // Issue the bitmap read on the accepting edge; write back at the end of the
  // busy cycle, so the next read is always taken after the write has landed.
  scba_map_ram #(
    .DEPTH (NUM_CLASSES),
    .WIDTH (SW)
  ) u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept && !in_info.no_class),
    .rd_addr (in_info.cls[AW-1:0]),
    .wr_en   (wr_en),
    .wr_addr (op_cls_r[AW-1:0]),
    .wr_data (wr_word),
    .rd_data (word)
  );

  always_comb begin
    unique case (state_r)
      ST_IDLE: state_nxt = accept ? ST_RMW : ST_IDLE;
      ST_RMW:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_action_r   <= in_action;
      op_no_class_r <= in_info.no_class;
      op_cls_r      <= in_info.cls;
      op_slot_r     <= in_slot_to_free;
    end
  end

  // Lowest free slot of the fetched word
  always_comb begin
    any_free   = |word;
    first_free = '0;
    for (int i = SW - 1; i >= 0; i--) begin
      if (word[i]) begin
        first_free = 6'(i);
      end
    end
  end

  always_comb begin
    slot_bad = ({1'b0, op_slot_r} >= 7'(SLOTS_PER_CLASS)) || word[op_slot_r];
  end

  // Modify the word and build the result
  always_comb begin
    wr_en       = 1'b0;
    wr_word     = word;
    res_status  = STS_OK;
    res_cls     = op_cls_r[3:0];
    res_idx     = '0;
    res_granted = '0;
    priority if (op_no_class_r) begin
      res_status = STS_NO_CLASS;
      res_cls    = '0;
    end else if (op_action_r == ACT_ALLOC) begin
      if (!any_free) begin
        res_status = STS_FULL;
      end else begin
        wr_en       = busy;
        wr_word     = word & ~({{(SW-1){1'b0}}, 1'b1} << first_free);
        res_idx     = first_free;
        res_granted = (op_cls_r[RAW_CLS_W-1:4] == '0) ? (16'd1 << op_cls_r[3:0]) : 16'd0;
      end
    end else begin
      res_idx = op_slot_r;
      if (slot_bad) begin
        res_status = STS_BAD_SLOT;
      end else begin
        wr_en   = busy;
        wr_word = word | ({{(SW-1){1'b0}}, 1'b1} << op_slot_r);
      end
    end
  end

  // Result strobe: one cycle, no hold-off
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      out_status_r        <= res_status;
      out_size_class_r    <= res_cls;
      out_slot_index_r    <= res_idx;
      out_granted_bytes_r <= res_granted;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_size_class    = out_size_class_r;
  assign out_slot_index    = out_slot_index_r;
  assign out_granted_bytes = out_granted_bytes_r;

endmodule

`default_nettype wire

[rtl/scba_chk.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// scba_chk
// Port-level checks for the slot allocator, bound to the top level.
// ---------------------------------------------------------------------------
module scba_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        out_valid,
  input wire logic [1:0]  out_status,
  input wire logic [3:0]  out_size_class,
  input wire logic [5:0]  out_slot_index,
  input wire logic [15:0] out_granted_bytes
);
  import scba_pkg::*;

  // An accepted transaction raises busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  // Busy cycle ends in a result strobe with busy dropped
  a_busy_result: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> (out_valid && !busy))
    else $error("busy cycle did not produce a result");

  // Every strobe comes from a busy cycle
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a transaction");

  // Failed results grant nothing
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != STS_OK) |-> (out_granted_bytes == 16'd0))
    else $error("failed transaction granted bytes");

  // No class: size class and slot index clear
  a_no_class: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STS_NO_CLASS) |->
      (out_size_class == 4'd0 && out_slot_index == 6'd0))
    else $error("no-class result carries class or slot");

endmodule

bind size_class_bitmap_slot_allocator scba_chk u_scba_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_status        (out_status),
  .out_size_class    (out_size_class),
  .out_slot_index    (out_slot_index),
  .out_granted_bytes (out_granted_bytes)
);

`default_nettype wire
